>>> design/mvm_pkg.sv
// Shared constants and types for the matrix-vector multiply core.
`default_nettype none
package mvm_pkg;

    // Store sizes
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;

    // Field and counter widths
    localparam int COL_W       = $clog2(MAX_COLUMNS);     // column / vector address
    localparam int COL_CNT_W   = COL_W + 1;               // column count register
    localparam int ROW_W       = $clog2(MAX_ROWS);        // row index
    localparam int ROW_CNT_W   = ROW_W + 1;               // row count register
    localparam int VALUE_W     = 32;
    localparam int ACC_W       = 64;
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int FRAC_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = ROW_CNT_W;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    // Stream widths
    localparam int S_TDATA_W   = VALUE_W;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 48;                      // row_index + sum, byte padded
    localparam int M_TUSER_W   = 1;

    // Input selector codes
    localparam logic MODE_VECTOR = 1'b0;
    localparam logic MODE_MATRIX = 1'b1;

    // Result queue
    localparam int OQ_DEPTH    = 8;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = OQ_PTR_W + 1;

    typedef struct packed {
        logic               last;
        logic               saturated;
        logic [VALUE_W-1:0] sum;
        logic [ROW_W-1:0]   row_index;
    } result_t;

endpackage
`default_nettype wire

>>> design/matrix_vector_multiply_core.sv
// Matrix-vector multiply core: vector store, multiply-accumulate pipeline, result queue.
// A row's result is presented after its last element passes stages 1 to 3 and the result queue.
// Throughput: one item per cycle (vector loads and matrix elements alike) while s_tready is
// high; it is set by the single read port of the vector store and the one multiplier.
// Reset (rst_n, async, active low) clears positions, accumulator, queue and counts (1);
// the vector store is not cleared and must be loaded before matrix elements arrive.
`default_nettype none
module matrix_vector_multiply_core (
    input  wire                              clk,
    input  wire                              rst_n,
    // input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [mvm_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] value
    input  wire  [mvm_pkg::S_TUSER_W-1:0]    s_tuser,   // [0] mode
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [mvm_pkg::M_TDATA_W-1:0]    m_tdata,   // [11:0] row_index, [43:12] sum
    output logic [mvm_pkg::M_TUSER_W-1:0]    m_tuser,   // [0] saturated
    output logic                             m_tlast,
    // configuration
    input  wire                              cfg_we,
    input  wire  [mvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [mvm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mvm_pkg::*;

    localparam logic [COL_CNT_W-1:0] MAX_COLS_C = COL_CNT_W'(MAX_COLUMNS);
    localparam logic [ROW_CNT_W-1:0] MAX_ROWS_C = ROW_CNT_W'(MAX_ROWS);

    // Configuration registers
    logic [ROW_CNT_W-1:0] row_count_reg;
    logic [COL_CNT_W-1:0] column_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_CNT_W'(1);
            column_count_reg <= COL_CNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[COL_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts: zero acts as one, clipped to the store size
    logic [COL_CNT_W-1:0] cols_eff;
    logic [ROW_CNT_W-1:0] rows_eff;

    always_comb
    begin
        if (column_count_reg == '0)
            cols_eff = COL_CNT_W'(1);
        else if (column_count_reg > MAX_COLS_C)
            cols_eff = MAX_COLS_C;
        else
            cols_eff = column_count_reg;

        if (row_count_reg == '0)
            rows_eff = ROW_CNT_W'(1);
        else if (row_count_reg > MAX_ROWS_C)
            rows_eff = MAX_ROWS_C;
        else
            rows_eff = row_count_reg;
    end

    // Input beat decode
    logic               in_beat;
    logic               vec_beat;
    logic               mat_beat;
    logic [VALUE_W-1:0] in_value;

    assign in_beat  = s_tvalid && s_tready;
    assign vec_beat = in_beat && (s_tuser[0] == MODE_VECTOR);
    assign mat_beat = in_beat && (s_tuser[0] == MODE_MATRIX);
    assign in_value = s_tdata[VALUE_W-1:0];

    // Position counters
    logic [COL_W-1:0]     vec_idx_reg;
    logic [COL_W-1:0]     vec_idx_next;
    logic [COL_W-1:0]     vec_wr_addr;
    logic [COL_CNT_W-1:0] vec_idx_inc;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [COL_CNT_W-1:0] col_inc;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [ROW_CNT_W-1:0] row_inc;
    logic                 col_in_range;
    logic                 row_end;
    logic                 row_last;

    always_comb
    begin
        // vector load address wraps at the column count
        vec_wr_addr  = ({1'b0, vec_idx_reg} >= cols_eff) ? '0 : vec_idx_reg;
        vec_idx_inc  = {1'b0, vec_wr_addr} + COL_CNT_W'(1);
        vec_idx_next = (vec_idx_inc >= cols_eff) ? '0 : vec_idx_inc[COL_W-1:0];

        // matrix position
        col_in_range = {1'b0, col_reg} < cols_eff;
        col_inc      = {1'b0, col_reg} + COL_CNT_W'(1);
        row_end      = col_inc >= cols_eff;
        col_next     = row_end ? '0 : col_inc[COL_W-1:0];
        row_inc      = {1'b0, row_reg} + ROW_CNT_W'(1);
        row_last     = row_inc >= rows_eff;
        row_next     = row_end ? (row_last ? '0 : row_inc[ROW_W-1:0]) : row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_idx_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            if (vec_beat)
                vec_idx_reg <= vec_idx_next;
            if (mat_beat)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Vector store: one write port for loads, one registered read for matrix beats
    logic [VALUE_W-1:0] vec_mem [MAX_COLUMNS];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (vec_beat)
            vec_mem[vec_wr_addr] <= in_value;
        if (mat_beat)
            rd_data_reg <= vec_mem[col_reg];
    end

    // Stage 1: element and its row bookkeeping, aligned with the store read
    logic               s1_valid_reg;
    logic               s1_in_range_reg;
    logic               s1_end_reg;
    logic               s1_last_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= mat_beat;
    end

    always_ff @(posedge clk)
    begin
        if (mat_beat)
        begin
            s1_in_range_reg <= col_in_range;
            s1_end_reg      <= row_end;
            s1_last_reg     <= row_last;
            s1_row_reg      <= row_reg;
            s1_value_reg    <= in_value;
        end
    end

    // Stage 2: exact Q32.32 product
    logic                     s2_valid_reg;
    logic                     s2_in_range_reg;
    logic                     s2_end_reg;
    logic                     s2_last_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = $signed(s1_value_reg) * $signed(rd_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_in_range_reg <= s1_in_range_reg;
            s2_end_reg      <= s1_end_reg;
            s2_last_reg     <= s1_last_reg;
            s2_row_reg      <= s1_row_reg;
            prod_reg        <= prod_next;
        end
    end

    // Stage 3: round half up to Q16.16 (carry-in of bit 15) and accumulate
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] term;
    logic             round_cin;
    logic             s3_valid_reg;
    logic             s3_last_reg;
    logic [ROW_W-1:0] s3_row_reg;
    logic [ACC_W-1:0] total_reg;

    always_comb
    begin
        if (s2_in_range_reg)
        begin
            term      = {{FRAC_W{prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:FRAC_W]};
            round_cin = prod_reg[FRAC_W-1];
        end
        else
        begin
            term      = '0;
            round_cin = 1'b0;
        end
        acc_next = acc_reg + term + ACC_W'(round_cin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg && s2_end_reg;
            if (s2_valid_reg)
                acc_reg <= s2_end_reg ? '0 : acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_end_reg)
        begin
            total_reg   <= acc_next;
            s3_last_reg <= s2_last_reg;
            s3_row_reg  <= s2_row_reg;
        end
    end

    // Saturate the row total to Q16.16
    logic    sat_hit;
    result_t res_next;

    always_comb
    begin
        sat_hit = !((&total_reg[ACC_W-1:VALUE_W-1]) || !(|total_reg[ACC_W-1:VALUE_W-1]));
        res_next.row_index = s3_row_reg;
        res_next.saturated = sat_hit;
        res_next.last      = s3_last_reg;
        if (!sat_hit)
            res_next.sum = total_reg[VALUE_W-1:0];
        else if (total_reg[ACC_W-1])
            res_next.sum = {1'b1, {(VALUE_W-1){1'b0}}};
        else
            res_next.sum = {1'b0, {(VALUE_W-1){1'b1}}};
    end

    // Result queue; input is held off while queued plus in-flight results could overflow it
    result_t             oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_ptr_reg;
    logic [OQ_PTR_W-1:0] oq_rd_ptr_reg;
    logic [OQ_CNT_W-1:0] oq_cnt_reg;
    logic [OQ_CNT_W-1:0] pending;
    logic                oq_push;
    logic                oq_pop;
    result_t             oq_head;

    assign oq_push = s3_valid_reg;
    assign oq_pop  = m_tvalid && m_tready;
    assign pending = oq_cnt_reg
                   + OQ_CNT_W'(s1_valid_reg && s1_end_reg)
                   + OQ_CNT_W'(s2_valid_reg && s2_end_reg)
                   + OQ_CNT_W'(s3_valid_reg);
    assign s_tready = pending < OQ_CNT_W'(OQ_DEPTH);

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_ptr_reg] <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_ptr_reg <= oq_wr_ptr_reg + OQ_PTR_W'(1);
            if (oq_pop)
                oq_rd_ptr_reg <= oq_rd_ptr_reg + OQ_PTR_W'(1);
            oq_cnt_reg <= oq_cnt_reg + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        end
    end

    // Output beat
    assign oq_head  = oq_mem[oq_rd_ptr_reg];
    assign m_tvalid = oq_cnt_reg != '0;
    assign m_tdata  = M_TDATA_W'({oq_head.sum, oq_head.row_index});
    assign m_tuser  = oq_head.saturated;
    assign m_tlast  = oq_head.last;

endmodule
`default_nettype wire
